// File: rtl/gads_pkg.sv
// Package: sizes, command and status codes, sequencer states for the graph store.
package gads_pkg;

  localparam int MaxVertices = 256;
  localparam int MaxDegree   = 16;
  localparam int IdWidth     = 32;
  localparam int VIdxW       = $clog2(MaxVertices);
  localparam int VCntW       = VIdxW + 1;
  localparam int DegW        = $clog2(MaxDegree + 1);
  localparam int NIdxW       = $clog2(MaxDegree);
  localparam int NAddrW      = VIdxW + NIdxW;
  localparam int SumW        = 13;

  typedef enum logic [2:0] {
    CmdClear = 3'd0,
    CmdLoad  = 3'd1,
    CmdEdge  = 3'd2,
    CmdDeg   = 3'd3,
    CmdNbr   = 3'd4,
    CmdStats = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StNotFound = 3'd1,
    StFull     = 3'd2,
    StEmpty    = 3'd3,
    StIndex    = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    SIdle,
    SSearch,
    SCheck,
    SNbrRd,
    SNbrOut,
    SApp1,
    SApp2,
    SDiv,
    SOut
  } state_e;

endpackage

// File: rtl/graph_adjacency_degree_store.sv
// Top level of the graph adjacency and degree store.
//
//  channel | signals                                             | dir
//  --------+-----------------------------------------------------+----
//  in      | in_valid_i, in_ready_o, command_i, vertex_a_i,      | in
//          | vertex_b_i, neighbor_index_i                        |
//  out     | out_valid_o, out_ready_i, status_o, value_o,        | out
//          | max_degree_o, avg_degree_o, self_loop_entries_o     |
//
// One command at a time. A binary search takes up to VIdxW+1 probes, each an
// address step and then a registered vertex table data step, plus a closing step; an
// edge runs two searches. Every result ends with a restoring divide of degree_sum
// by vertex_count, one quotient bit per cycle.
// Reset clears the counters and control; tables need no clearing. in_ready_o
// is low from a transfer until its result is taken.
module graph_adjacency_degree_store
  import gads_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            command_i,
  input  logic [IdWidth-1:0]    vertex_a_i,
  input  logic [IdWidth-1:0]    vertex_b_i,
  input  logic [3:0]            neighbor_index_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            status_o,
  output logic [31:0]           value_o,
  output logic [4:0]            max_degree_o,
  output logic [4:0]            avg_degree_o,
  output logic [12:0]           self_loop_entries_o
);

  // Memories.
  logic [IdWidth-1:0] vtab [MaxVertices];
  logic [DegW-1:0]    dtab [MaxVertices];
  logic [IdWidth-1:0] nstore [MaxVertices*MaxDegree];

  state_e state_q, state_d;

  logic [2:0]         cmd_q;
  logic [IdWidth-1:0] a_q, b_q;
  logic [NIdxW-1:0]   idx_q;
  logic [VCntW-1:0]   vcount_q;
  logic [SumW-1:0]    dsum_q;
  logic [DegW-1:0]    rmax_q;
  logic [SumW-1:0]    loops_q;
  logic [IdWidth-1:0] last_id_q;

  // Search registers.
  logic [VCntW-1:0]   lo_q, hi_q;
  logic               second_q;      // searching endpoint b
  logic               found_a_q;
  logic [VIdxW-1:0]   pos_a_q, pos_b_q;
  logic [IdWidth-1:0] vrd_q;         // registered vertex table read
  logic               vrd_ok_q;
  logic               probe_q;       // high in the data step of a probe
  logic [VCntW-1:0]   mid;
  logic [DegW-1:0]    dega_q, degb_q;
  logic [DegW-1:0]    drd_q;         // registered degree table read
  logic [IdWidth-1:0] nrd_q;
  logic               app_ok;

  // Divider.
  logic [SumW-1:0]    quo_q;
  logic [VCntW:0]     rem_q;
  logic [$clog2(SumW+1)-1:0] dcnt_q;

  logic [2:0]         status_q;
  logic [31:0]        value_q;
  logic               ovalid_q;

  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  // Both lists have room for the edge (two entries for a self-loop).
  assign app_ok = (pos_a_q == pos_b_q) ?
                  (dega_q + DegW'(2) <= DegW'(MaxDegree)) :
                  (dega_q + DegW'(1) <= DegW'(MaxDegree) &&
                   degb_q + DegW'(1) <= DegW'(MaxDegree));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: if (in_valid_i) begin
        case (command_i)
          CmdEdge, CmdDeg, CmdNbr: state_d = SSearch;
          default:                 state_d = SDiv;
        endcase
      end
      SSearch: if (lo_q >= hi_q) state_d = SCheck;
      SCheck: begin
        if (cmd_q == CmdEdge && !second_q && vrd_ok_q && vrd_q == a_q)
          state_d = SSearch;
        else if (!(vrd_ok_q && vrd_q == (second_q ? b_q : a_q)))
          state_d = SDiv;
        else if (cmd_q == CmdNbr)
          state_d = SNbrRd;
        else if (cmd_q == CmdEdge)
          state_d = SApp1;
        else
          state_d = SDiv;
      end
      SNbrRd:  state_d = SNbrOut;
      SNbrOut: state_d = SDiv;
      SApp1:   state_d = SApp2;
      SApp2:   state_d = SDiv;
      SDiv:    if (dcnt_q == '0) state_d = SOut;
      SOut:    if (out_ready_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o          = (state_q == SIdle);
    out_valid_o         = ovalid_q;
    status_o            = status_q;
    value_o             = value_q;
    max_degree_o        = rmax_q;
    avg_degree_o        = (vcount_q == '0) ? 5'd0 : quo_q[4:0];
    self_loop_entries_o = loops_q;
  end

  // Vertex table read port: probe the midpoint, registered.
  always_ff @(posedge clk_i) begin
    vrd_q <= vtab[mid[VIdxW-1:0]];
    if (state_q == SIdle && in_valid_i && command_i == CmdLoad &&
        vcount_q < VCntW'(MaxVertices) &&
        (vcount_q == '0 || vertex_a_i > last_id_q)) begin
      vtab[vcount_q[VIdxW-1:0]] <= vertex_a_i;
    end
  end

  // Degree table: registered read at the search position.
  always_ff @(posedge clk_i) begin
    drd_q <= dtab[lo_q[VIdxW-1:0]];
    if (state_q == SIdle && in_valid_i && command_i == CmdLoad &&
        vcount_q < VCntW'(MaxVertices) &&
        (vcount_q == '0 || vertex_a_i > last_id_q)) begin
      dtab[vcount_q[VIdxW-1:0]] <= '0;
    end else if (state_q == SApp1 && app_ok) begin
      dtab[pos_a_q] <= dega_q + ((pos_a_q == pos_b_q) ? DegW'(2) : DegW'(1));
    end else if (state_q == SApp2 && app_ok && pos_a_q != pos_b_q) begin
      dtab[pos_b_q] <= degb_q + DegW'(1);
    end
  end

  // Neighbor store: one write per append cycle, one registered read.
  always_ff @(posedge clk_i) begin
    nrd_q <= nstore[{pos_a_q, idx_q}];
    if (state_q == SApp1 && app_ok) begin
      nstore[{pos_a_q, dega_q[NIdxW-1:0]}] <= b_q;
    end else if (state_q == SApp2 && app_ok) begin
      if (pos_a_q == pos_b_q)
        nstore[{pos_a_q, NIdxW'(dega_q + DegW'(1))}] <= a_q;
      else
        nstore[{pos_b_q, degb_q[NIdxW-1:0]}] <= a_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      vcount_q  <= '0;
      dsum_q    <= '0;
      rmax_q    <= '0;
      loops_q   <= '0;
      ovalid_q  <= 1'b0;
      last_id_q <= '0;
      dcnt_q    <= '0;
      probe_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        SIdle: if (in_valid_i) begin
          cmd_q     <= command_i;
          a_q       <= vertex_a_i;
          b_q       <= vertex_b_i;
          idx_q     <= neighbor_index_i[NIdxW-1:0];
          status_q  <= StOk;
          value_q   <= '0;
          lo_q      <= '0;
          hi_q      <= vcount_q;
          second_q  <= 1'b0;
          vrd_ok_q  <= 1'b0;
          probe_q   <= 1'b0;
          case (command_i)
            CmdClear: begin
              vcount_q <= '0;
              dsum_q   <= '0;
              rmax_q   <= '0;
              loops_q  <= '0;
            end
            CmdLoad: begin
              if (vcount_q >= VCntW'(MaxVertices) ||
                  (vcount_q != '0 && vertex_a_i <= last_id_q)) begin
                status_q <= StFull;
              end else begin
                vcount_q  <= vcount_q + 1'b1;
                last_id_q <= vertex_a_i;
              end
            end
            CmdStats: if (vcount_q == '0) status_q <= StEmpty;
            default: ;
          endcase
          dcnt_q <= $bits(dcnt_q)'(SumW);
          quo_q  <= '0;
          rem_q  <= '0;
        end
        SSearch: begin
          if (lo_q < hi_q) begin
            vrd_ok_q <= 1'b0;
            probe_q  <= ~probe_q;
            // Data step of a probe: vrd_q holds the entry at the midpoint.
            if (probe_q) begin
              if (vrd_q < (second_q ? b_q : a_q))
                lo_q <= mid + 1'b1;
              else
                hi_q <= mid;
            end
          end else begin
            vrd_ok_q <= (lo_q < vcount_q);
          end
          if (second_q) pos_b_q <= lo_q[VIdxW-1:0];
          else          pos_a_q <= lo_q[VIdxW-1:0];
        end
        SCheck: begin
          if (!(vrd_ok_q && vrd_q == (second_q ? b_q : a_q))) begin
            status_q <= StNotFound;
          end else begin
            if (second_q) degb_q <= drd_q;
            else          dega_q <= drd_q;
            if (cmd_q == CmdEdge && !second_q) begin
              second_q <= 1'b1;
              lo_q     <= '0;
              hi_q     <= vcount_q;
            end else if (cmd_q == CmdDeg) begin
              value_q <= 32'(drd_q);
            end else if (cmd_q == CmdNbr && {1'b0, idx_q} >= drd_q) begin
              status_q <= StIndex;
            end
          end
        end
        SNbrRd: ;
        SNbrOut: if (status_q == StOk) value_q <= nrd_q;
        SApp1: begin
          if (pos_a_q == pos_b_q) begin
            if (dega_q + DegW'(2) > DegW'(MaxDegree)) status_q <= StFull;
            else begin
              dsum_q  <= dsum_q + SumW'(2);
              loops_q <= loops_q + SumW'(2);
              if (dega_q + DegW'(2) > rmax_q) rmax_q <= dega_q + DegW'(2);
            end
          end else if (dega_q + DegW'(1) > DegW'(MaxDegree) ||
                       degb_q + DegW'(1) > DegW'(MaxDegree)) begin
            status_q <= StFull;
          end else begin
            dsum_q <= dsum_q + SumW'(2);
            if (dega_q + DegW'(1) > rmax_q && dega_q >= degb_q)
              rmax_q <= dega_q + DegW'(1);
            else if (degb_q + DegW'(1) > rmax_q)
              rmax_q <= degb_q + DegW'(1);
          end
        end
        SApp2: ;
        SDiv: if (dcnt_q != '0) begin
          // Restoring divide: one quotient bit per cycle.
          logic [VCntW:0] trial;
          trial = {rem_q[VCntW-1:0], dsum_q[dcnt_q - 1'b1]};
          if (trial >= {1'b0, vcount_q} && vcount_q != '0) begin
            rem_q <= trial - {1'b0, vcount_q};
            quo_q <= {quo_q[SumW-2:0], 1'b1};
          end else begin
            rem_q <= trial;
            quo_q <= {quo_q[SumW-2:0], 1'b0};
          end
          dcnt_q <= dcnt_q - 1'b1;
        end else begin
          // Raise the result as the sequencer moves to SOut.
          ovalid_q <= 1'b1;
        end
        SOut: if (out_ready_i) ovalid_q <= 1'b0;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/gads_checker.sv
// Port-level checker for the graph store, bound to the top level.
module gads_checker
  import gads_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [31:0] value_o
);
  // Never take a new item while a result waits.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready while result pending");
  // A result holds until its transfer.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(value_o))
    else $error("result dropped");
  // A non-ok status carries a zero value.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StOk |-> value_o == '0) else $error("value on error");
  // An accepted item drops ready next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready after transfer");
endmodule

bind graph_adjacency_degree_store gads_checker u_gads_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .status_o, .value_o
);

// File: sim/tb.sv
// Self-checking testbench for the graph adjacency and degree store.
module tb;
  import gads_pkg::*;

  localparam logic [2:0] CmdRsv6 = 3'd6;
  localparam logic [2:0] CmdRsv7 = 3'd7;
  localparam int CycleLimit = 400000;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] a;
    logic [31:0] b;
    logic [3:0]  idx;
    bit          sync;  // wait until every result is back before this transfer
  } cmd_item_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] value;
    logic [4:0]  max_deg;
    logic [4:0]  avg_deg;
    logic [12:0] loops;
  } graph_res_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [2:0] command_i, status_o;
  logic [31:0] vertex_a_i, vertex_b_i, value_o;
  logic [3:0] neighbor_index_i;
  logic [4:0] max_degree_o, avg_degree_o;
  logic [12:0] self_loop_entries_o;

  graph_adjacency_degree_store i_dut (.*);

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  cmd_item_t  cmd_q[$];
  graph_res_t result_q[$];
  int errors = 0;
  int n_accepted = 0;
  int cycles = 0;
  bit in_taken = 0;

  // Shadow graph state.
  logic [31:0] sh_vtab[MaxVertices];
  int          sh_vcnt;
  int          sh_deg[MaxVertices];
  logic [31:0] sh_nbr[MaxVertices*MaxDegree];
  int          sh_sum, sh_max, sh_loops;

  function automatic bit lookup_vertex(logic [31:0] id, output int pos);
    int lo, hi, mid;
    lo = 0;
    hi = sh_vcnt;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (sh_vtab[mid] < id) lo = mid + 1;
      else hi = mid;
    end
    pos = lo;
    return (lo < sh_vcnt) && (sh_vtab[lo] == id);
  endfunction

  function automatic void add_neighbor(int v, logic [31:0] id);
    sh_nbr[v*MaxDegree + sh_deg[v]] = id;
    sh_deg[v]++;
    sh_sum++;
    if (sh_deg[v] > sh_max) sh_max = sh_deg[v];
  endfunction

  function automatic graph_res_t apply_command(cmd_item_t it);
    graph_res_t r;
    int i, j;
    r.status = StOk;
    r.value = '0;
    case (it.cmd)
      CmdClear: begin
        sh_vcnt = 0; sh_sum = 0; sh_max = 0; sh_loops = 0;
      end
      CmdLoad: begin
        if (sh_vcnt >= MaxVertices || (sh_vcnt > 0 && it.a <= sh_vtab[sh_vcnt-1])) begin
          r.status = StFull;
        end else begin
          sh_vtab[sh_vcnt] = it.a;
          sh_deg[sh_vcnt] = 0;
          sh_vcnt++;
        end
      end
      CmdEdge: begin
        if (!lookup_vertex(it.a, i) || !lookup_vertex(it.b, j)) begin
          r.status = StNotFound;
        end else if (i == j) begin
          if (sh_deg[i] + 2 > MaxDegree) r.status = StFull;
          else begin
            add_neighbor(i, it.b);
            add_neighbor(i, it.a);
            sh_loops += 2;
          end
        end else if (sh_deg[i] + 1 > MaxDegree || sh_deg[j] + 1 > MaxDegree) begin
          r.status = StFull;
        end else begin
          add_neighbor(i, it.b);
          add_neighbor(j, it.a);
        end
      end
      CmdDeg: begin
        if (!lookup_vertex(it.a, i)) r.status = StNotFound;
        else r.value = 32'(sh_deg[i]);
      end
      CmdNbr: begin
        if (!lookup_vertex(it.a, i)) r.status = StNotFound;
        else if (it.idx >= sh_deg[i]) r.status = StIndex;
        else r.value = sh_nbr[i*MaxDegree + it.idx];
      end
      CmdStats: if (sh_vcnt == 0) r.status = StEmpty;
      default: ;
    endcase
    r.max_deg = 5'(sh_max);
    r.avg_deg = (sh_vcnt == 0) ? 5'd0 : 5'(sh_sum / sh_vcnt);
    r.loops = 13'(sh_loops);
    return r;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h, expected %0h at cycle %0d", field, got, want, cycles);
    errors++;
  endtask

  // Sample both handshakes at the rising edge.
  always @(posedge clk_i) begin
    graph_res_t w;
    cmd_item_t it;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
    in_taken = 0;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (result_q.size() == 0) begin
          $display("unexpected result at cycle %0d", cycles);
          errors++;
        end else begin
          w = result_q.pop_front();
          if (status_o !== w.status) report("status", 32'(status_o), 32'(w.status));
          if (value_o !== w.value) report("value", value_o, w.value);
          if (max_degree_o !== w.max_deg)
            report("max_degree", 32'(max_degree_o), 32'(w.max_deg));
          if (avg_degree_o !== w.avg_deg)
            report("avg_degree", 32'(avg_degree_o), 32'(w.avg_deg));
          if (self_loop_entries_o !== w.loops)
            report("self_loop_entries", 32'(self_loop_entries_o), 32'(w.loops));
        end
      end
      if (in_valid_i && in_ready_o) begin
        it.cmd = command_i; it.a = vertex_a_i; it.b = vertex_b_i;
        it.idx = neighbor_index_i; it.sync = 0;
        result_q.push_back(apply_command(it));
        n_accepted++;
        in_taken = 1;
      end
    end
  end

  // Sender: bursts and gaps, change inputs on the falling edge.
  int burst_left = 0, gap_left = 0;
  always @(negedge clk_i) begin
    logic nv;
    cmd_item_t it;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_q.size() != 0 && !(cmd_q[0].sync && result_q.size() != 0)) begin
        it = cmd_q.pop_front();
        command_i <= it.cmd;
        vertex_a_i <= it.a;
        vertex_b_i <= it.b;
        neighbor_index_i <= it.idx;
        nv = 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      in_valid_i <= nv;
    end
  end

  // Receiver: own stall pattern plus one long hold-off.
  int seg_left = 0, rx_mode = 0, hold_left = 0;
  bit hold_done = 0;
  always @(negedge clk_i) begin
    if (!hold_done && n_accepted == 120) begin
      hold_done = 1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(5, 80);
        rx_mode = $urandom_range(0, 2);
      end
      seg_left--;
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 3) != 0);
        default: out_ready_i <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Stimulus generation; the IDs the generator believes are loaded.
  logic [31:0] gen_ids[$];

  task automatic push_cmd(logic [2:0] cmd, logic [31:0] a, logic [31:0] b,
                          logic [3:0] idx, bit sync = 0);
    cmd_item_t it;
    it.cmd = cmd; it.a = a; it.b = b; it.idx = idx; it.sync = sync;
    cmd_q.push_back(it);
  endtask

  function automatic logic [31:0] pick_id();
    if (gen_ids.size() != 0 && $urandom_range(0, 9) != 0)
      return gen_ids[$urandom_range(0, gen_ids.size() - 1)];
    return $urandom;
  endfunction

  initial begin
    int nv, nops, op;
    logic [63:0] next_id;
    logic [31:0] v;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    command_i = '0;
    vertex_a_i = '0;
    vertex_b_i = '0;
    neighbor_index_i = '0;
    sh_vcnt = 0; sh_sum = 0; sh_max = 0; sh_loops = 0;

    // Directed: empty graph, ordering, ID extremes, self-loops to overflow.
    push_cmd(CmdStats, 0, 0, 0);
    push_cmd(CmdDeg, 32'h0, 0, 0);
    push_cmd(CmdEdge, 32'h0, 32'hFFFF_FFFF, 0);
    push_cmd(CmdLoad, 32'h0, 0, 0);
    push_cmd(CmdLoad, 32'h0, 0, 0);
    push_cmd(CmdLoad, 32'hFFFF_FFFF, 0, 0);
    push_cmd(CmdLoad, 32'h5, 0, 0);
    repeat (8) push_cmd(CmdEdge, 32'h0, 32'h0, 0);
    push_cmd(CmdEdge, 32'h0, 32'h0, 0);
    push_cmd(CmdEdge, 32'h0, 32'hFFFF_FFFF, 0);
    push_cmd(CmdEdge, 32'hFFFF_FFFF, 32'h7, 0);
    push_cmd(CmdNbr, 32'h0, 0, 4'hF);
    push_cmd(CmdNbr, 32'hFFFF_FFFF, 0, 4'h0);
    push_cmd(CmdDeg, 32'h0, 0, 0);
    push_cmd(CmdStats, 0, 0, 0);
    push_cmd(CmdRsv6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
    push_cmd(CmdRsv7, 0, 0, 0);
    push_cmd(CmdClear, 0, 0, 0);
    push_cmd(CmdStats, 0, 0, 0);

    // Random phases: clear, ascending loads, then edges and queries.
    for (int ph = 0; cmd_q.size() < 450; ph++) begin
      gen_ids.delete();
      push_cmd(CmdClear, $urandom, $urandom, 4'($urandom), 1);
      if (ph == 2) nv = MaxVertices + 1;
      else if ($urandom_range(0, 7) == 0) nv = 0;
      else nv = $urandom_range(1, 8);
      next_id = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 50) : {32'h0, $urandom};
      for (int k = 0; k < nv; k++) begin
        if (next_id > 64'hFFFF_FFFF) break;
        push_cmd(CmdLoad, next_id[31:0], $urandom, 4'($urandom));
        if (gen_ids.size() < MaxVertices) gen_ids.push_back(next_id[31:0]);
        if (gen_ids.size() != 0 && $urandom_range(0, 9) == 0)
          push_cmd(CmdLoad, gen_ids[$], 0, 0);  // repeat: rejected as out of order
        next_id += (ph == 2) ? $urandom_range(1, 1000) : $urandom_range(1, 1 << 24);
      end
      nops = (ph == 2) ? 20 : $urandom_range(10, 40);
      for (int k = 0; k < nops; k++) begin
        op = $urandom_range(0, 19);
        if (op < 8) push_cmd(CmdEdge, pick_id(), pick_id(), 4'($urandom));
        else if (op < 10) begin
          v = pick_id();
          push_cmd(CmdEdge, v, v, 4'($urandom));
        end else if (op < 13) push_cmd(CmdDeg, pick_id(), $urandom, 4'($urandom));
        else if (op < 17) push_cmd(CmdNbr, pick_id(), $urandom, 4'($urandom));
        else if (op < 19) push_cmd(CmdStats, $urandom, $urandom, 4'($urandom));
        else push_cmd($urandom_range(0, 1) ? CmdRsv6 : CmdRsv7, $urandom, $urandom,
                      4'($urandom));
      end
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_q.size() != 0 || in_valid_i || result_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
